// ----- rtl/core/mrfc_pkg.sv -----
package mrfc_pkg;

    // Frame size limit and derived counter width
    localparam int MAX_FRAME = 255;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register defaults
    localparam logic       MASTER_MODE_RST    = 1'b1;
    localparam logic [7:0] OWN_ADDRESS_RST    = 8'h40;
    localparam logic [7:0] EXPECTED_SLAVE_RST = 8'h00;
    localparam logic [7:0] BROADCAST_ADDR     = 8'h00;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASTER_MODE    = 2'd0,
        CFG_OWN_ADDRESS    = 2'd1,
        CFG_EXPECTED_SLAVE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ADDR    = 3'd1,
        ST_SHORT   = 3'd2,
        ST_CRC     = 3'd3,
        ST_OVERRUN = 3'd4
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] data_byte;
        t_status    status;
        logic [7:0] payload_length;
        logic       last;
    } t_result;

    // Up to two result beats written per processed byte, in order
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result item0;
        t_result item1;
    } t_push;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One byte of CRC-16/Modbus, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mrfc_in_if.sv -----
interface mrfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ----- rtl/core/mrfc_out_if.sv -----
interface mrfc_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] payload_length;
    logic       last;

    modport source (output valid, output out_kind, output data_byte, output status,
                    output payload_length, output last, input ready);
    modport sink   (input valid, input out_kind, input data_byte, input status,
                    input payload_length, input last, output ready);
endinterface

// ----- rtl/core/mrfc_frame_eng.sv -----
module mrfc_frame_eng
    import mrfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  logic       i_master_mode,
    input  logic [7:0] i_own_address,
    input  logic [7:0] i_expected_slave,
    output t_push      o_push
);

    t_cnt        r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_older, n_older;
    logic [7:0]  r_newer, n_newer;
    logic        r_addr_ok, n_addr_ok;
    logic        r_ovr, n_ovr;

    logic        take;
    logic        pay_v;
    logic [7:0]  match_addr;
    logic [15:0] rx_crc;
    t_cnt        diff;
    logic [CNT_W+7:0] diff_wide;
    logic [7:0]  plen;
    t_status     st;
    t_result     pay_item;
    t_result     st_item;

    always_comb begin
        take       = (r_count < t_cnt'(MAX_FRAME));
        match_addr = i_master_mode ? i_expected_slave : i_own_address;

        n_count   = r_count;
        n_crc     = r_crc;
        n_older   = r_older;
        n_newer   = r_newer;
        n_addr_ok = r_addr_ok;
        n_ovr     = r_ovr | ~take;
        pay_v     = take && (r_count >= t_cnt'(3));

        if (take) begin
            if (r_count == '0) begin
                n_addr_ok = (i_byte == BROADCAST_ADDR) || (i_byte == match_addr);
            end
            if (r_count >= t_cnt'(2)) begin
                n_crc = crc_byte(r_crc, r_older);
            end
            n_older = r_newer;
            n_newer = i_byte;
            n_count = r_count + t_cnt'(1);
        end

        // Frame-end check on the updated frame state
        rx_crc = {n_newer, n_older};
        priority if (!n_addr_ok) begin
            st = ST_ADDR;
        end else if (n_ovr) begin
            st = ST_OVERRUN;
        end else if (n_count < t_cnt'(4)) begin
            st = ST_SHORT;
        end else if (n_crc != rx_crc) begin
            st = ST_CRC;
        end else begin
            st = ST_OK;
        end

        diff      = (n_count > t_cnt'(3)) ? (n_count - t_cnt'(3)) : '0;
        diff_wide = {8'h00, diff};
        plen      = (diff_wide > (CNT_W+8)'(255)) ? 8'hFF : diff_wide[7:0];

        pay_item.out_kind       = KIND_PAYLOAD;
        pay_item.data_byte      = r_older;
        pay_item.status         = ST_OK;
        pay_item.payload_length = 8'h00;
        pay_item.last           = 1'b0;

        st_item.out_kind       = KIND_STATUS;
        st_item.data_byte      = 8'h00;
        st_item.status         = st;
        st_item.payload_length = plen;
        st_item.last           = 1'b1;

        o_push.v0    = i_go && (pay_v || i_end);
        o_push.v1    = i_go && pay_v && i_end;
        o_push.item0 = pay_v ? pay_item : st_item;
        o_push.item1 = st_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_older   <= 8'h00;
            r_newer   <= 8'h00;
            r_addr_ok <= 1'b0;
            r_ovr     <= 1'b0;
        end else if (i_go) begin
            if (i_end) begin
                r_count   <= '0;
                r_crc     <= CRC_INIT;
                r_older   <= 8'h00;
                r_newer   <= 8'h00;
                r_addr_ok <= 1'b0;
                r_ovr     <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_crc     <= n_crc;
                r_older   <= n_older;
                r_newer   <= n_newer;
                r_addr_ok <= n_addr_ok;
                r_ovr     <= n_ovr;
            end
        end
    end

endmodule

// ----- rtl/core/mrfc_out_fifo.sv -----
module mrfc_out_fifo
    import mrfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room2,
    output logic    o_valid,
    output t_result o_item,
    input  logic    i_pop
);

    t_result             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp, r_rp;
    logic [FIFO_AW:0]    r_cnt;
    logic                pop;
    logic [FIFO_AW:0]    n_push;
    logic [FIFO_AW-1:0]  wp1;

    always_comb begin
        pop     = i_pop && (r_cnt != '0);
        n_push  = (FIFO_AW+1)'(i_push.v0) + (FIFO_AW+1)'(i_push.v1);
        wp1     = r_wp + FIFO_AW'(1);
        o_room2 = (r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
        o_valid = (r_cnt != '0);
        o_item  = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.item0;
        end
        if (i_push.v1) begin
            r_mem[wp1] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_push[FIFO_AW-1:0];
            r_rp  <= r_rp + FIFO_AW'(pop);
            r_cnt <= r_cnt + n_push - (FIFO_AW+1)'(pop);
        end
    end

endmodule

// ----- rtl/core/modbus_rtu_frame_checker_unit.sv -----
// Modbus RTU receive frame checker: address filter, CRC-16/Modbus check, payload pass-out.
// Path: an accepted byte is held in the input register, and its result beats are then written
//   into the result queue, whose head is offered on the output.
// Throughput: one byte per cycle; a frame-end byte with a payload beat makes two output
//   beats, drained one a cycle while the output is ready from a four-entry result queue;
//   input stalls only while more than two beats wait in the queue.
// Reset (i_rst_n, synchronous, active low): frame state cleared, queue emptied,
//   configuration back to master mode, own address 0x40, expected slave 0.
module modbus_rtu_frame_checker_unit
    import mrfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mrfc_in_if.sink               i_in,
    mrfc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic       r_master_mode;
    logic [7:0] r_own_address;
    logic [7:0] r_expected_slave;

    // Input register: one beat held ahead of the frame engine
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic       go;
    logic       room2;
    t_push      push;
    t_result    head;

    // The engine steps whenever a held beat exists and the queue can take two results.
    assign go         = r_in_valid && room2;
    assign i_in.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_mode    <= MASTER_MODE_RST;
            r_own_address    <= OWN_ADDRESS_RST;
            r_expected_slave <= EXPECTED_SLAVE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MASTER_MODE:    r_master_mode    <= i_cfg_data[0];
                CFG_OWN_ADDRESS:    r_own_address    <= i_cfg_data;
                CFG_EXPECTED_SLAVE: r_expected_slave <= i_cfg_data;
                default: begin
                    // unused index: write ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
            r_in_end  <= i_in.frame_end;
        end
    end

    // Address, CRC and length state per frame; emits payload and status beats
    mrfc_frame_eng u_eng (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (go),
        .i_byte           (r_in_byte),
        .i_end            (r_in_end),
        .i_master_mode    (r_master_mode),
        .i_own_address    (r_own_address),
        .i_expected_slave (r_expected_slave),
        .o_push           (push)
    );

    // Result queue decouples the output handshake from the engine
    mrfc_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out.valid),
        .o_item  (head),
        .i_pop   (o_out.ready)
    );

    assign o_out.out_kind       = head.out_kind;
    assign o_out.data_byte      = head.data_byte;
    assign o_out.status         = head.status;
    assign o_out.payload_length = head.payload_length;
    assign o_out.last           = head.last;

endmodule
